@@ design/set_assoc_cache_tag_controller_core_macros.svh @@
// Assertion helpers shared by the tag controller RTL.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off while in reset.
`define SACTC_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("tag controller assertion failed");

// Next-cycle implication, checked on the rising clock, off while in reset.
`define SACTC_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("tag controller assertion failed");

`endif

@@ design/sactc_pkg.sv @@
`default_nettype none

package sactc_pkg;

  localparam int WAYS_DEFAULT = 8;
  localparam int SET_COUNT    = 128;
  localparam int SET_W        = 7;
  localparam int TAG_W        = 20;
  localparam int AGE_W        = 3;
  localparam int OFFSET_W     = 5;
  localparam int WAY_OUT_W    = 4;
  localparam logic [AGE_W-1:0] AGE_TOP = 3'h7;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 writeback;
    logic [TAG_W-1:0]     evicted_tag;
    logic                 write_miss;
  } rsp_t;

  // One way of one set as held in the tag memory.
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

`default_nettype wire

@@ design/set_assoc_cache_tag_controller_core.sv @@
`default_nettype none

// Set-associative write-back cache tag controller with counter ageing.
// Each request is a read or write to a 32-bit byte address (bits 11..5 pick
// one of 128 sets, bits 31..12 are the tag, bits 4..0 are ignored). The
// controller answers each request with exactly one result: hit and way, the
// filled way on a read miss (with a write-back notice and the evicted tag
// when it replaces a dirty line), or a write-miss flag (a write that misses
// changes nothing). All tag, valid, dirty and age state lives in one 128-row
// memory, one row per set holding every way; a row is read when the request
// is taken and written back on the edge that loads the request's result. The
// lookup state compares the tags, updates the ages and writes the row back;
// no new request is taken until the controller leaves it, and a stalled result
// holds the controller there until the result register frees up. No
// clearing pass follows reset: a per-row valid flop makes an untouched set
// read as all zero.
`include "set_assoc_cache_tag_controller_core_macros.svh"

module set_assoc_cache_tag_controller_core #(
  parameter int WAYS_PER_SET = sactc_pkg::WAYS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire sactc_pkg::req_t in_req,
  output logic              out_valid,
  input  wire logic         out_stall,
  output sactc_pkg::rsp_t   out_rsp
);

  localparam int WAY_W = $clog2(WAYS_PER_SET);

  typedef sactc_pkg::line_t [WAYS_PER_SET-1:0] row_t;

  // Tag memory: one row per set, one read and one write port.
  row_t row_mem [sactc_pkg::SET_COUNT];

  sactc_pkg::state_t state_r, state_nxt;

  logic [sactc_pkg::SET_COUNT-1:0] row_vld_r;   // row ever written since reset
  row_t                            rd_row_r;
  logic                            rd_vld_r;
  logic [sactc_pkg::SET_W-1:0]     set_r;
  logic [sactc_pkg::TAG_W-1:0]     tag_r;
  logic                            mode_r;

  logic                            out_valid_r, out_valid_nxt;
  sactc_pkg::rsp_t                 out_rsp_r;

  logic                        accept;
  logic                        out_load;
  logic                        mem_we;
  logic [sactc_pkg::SET_W-1:0] in_set;

  row_t                  cur_row;
  row_t                  new_row;
  logic                  hit;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      vic_way;
  logic [WAY_W-1:0]      sel_way;
  logic                  wr_miss;
  logic                  wback;
  sactc_pkg::rsp_t       rsp;

  assign in_set = in_req.address[sactc_pkg::OFFSET_W +: sactc_pkg::SET_W];
  assign accept = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sactc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sactc_pkg::ST_LOOKUP;
      end
      sactc_pkg::ST_LOOKUP: begin
        if (!out_valid_r || !out_stall) state_nxt = sactc_pkg::ST_IDLE;
      end
      default: state_nxt = sactc_pkg::ST_IDLE;
    endcase
  end

  // State outputs: take requests only when idle, finish when the result
  // register is free or draining this cycle.
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      sactc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      sactc_pkg::ST_LOOKUP: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sactc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the request fields needed by the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r  <= in_set;
      tag_r  <= in_req.address[31 -: sactc_pkg::TAG_W];
      mode_r <= in_req.mode;
    end
  end

  // Memory ports: read the set's row on accept, write the updated row back.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[set_r] <= new_row;
    end
    if (accept) begin
      rd_row_r <= row_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_vld_r <= row_vld_r[in_set];
    end
  end

  // A row never written reads as the reset contents (all zero).
  assign cur_row = rd_vld_r ? rd_row_r : '0;

  // Hit search: lowest valid matching way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS_PER_SET - 1; w >= 0; w--) begin
      if (cur_row[w].valid && (cur_row[w].tag == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // Victim: lowest way with age zero, else way 0.
  always_comb begin
    vic_way = '0;
    for (int w = WAYS_PER_SET - 1; w >= 0; w--) begin
      if (cur_row[w].age == '0) vic_way = WAY_W'(w);
    end
  end

  assign sel_way = hit ? hit_way : vic_way;
  assign wr_miss = !hit && mode_r;
  assign wback   = !hit && !mode_r && cur_row[vic_way].valid && cur_row[vic_way].dirty;

  // Row update: newest way to the top age, the rest count down to zero;
  // mark dirty on a write hit, install the new tag on a read miss.
  always_comb begin
    new_row = cur_row;
    for (int w = 0; w < WAYS_PER_SET; w++) begin
      if (WAY_W'(w) == sel_way) begin
        new_row[w].age = sactc_pkg::AGE_TOP;
        if (hit) begin
          new_row[w].dirty = cur_row[w].dirty || mode_r;
        end else begin
          new_row[w].valid = 1'b1;
          new_row[w].dirty = 1'b0;
          new_row[w].tag   = tag_r;
        end
      end else if (cur_row[w].age != '0) begin
        new_row[w].age = cur_row[w].age - sactc_pkg::AGE_W'(1);
      end
    end
  end

  // Drop the write-back of the row on a write miss: nothing changes.
  assign mem_we = out_load && !wr_miss;

  always_comb begin
    rsp.hit         = hit;
    rsp.way         = wr_miss ? '0 : sactc_pkg::WAY_OUT_W'(sel_way);
    rsp.writeback   = wback;
    rsp.evicted_tag = wback ? cur_row[vic_way].tag : '0;
    rsp.write_miss  = wr_miss;
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A taken request always moves to the lookup cycle and blocks the input.
  `SACTC_ASSERT_NEXT(a_accept_lookup, accept, (state_r == sactc_pkg::ST_LOOKUP) && in_stall)
  // A row write always produces a result the next cycle.
  `SACTC_ASSERT_NEXT(a_write_result, mem_we, out_valid_r)
  // A new result only ever comes out of the lookup cycle.
  `SACTC_ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(state_r == sactc_pkg::ST_LOOKUP))

endmodule

`default_nettype wire
